// File: sv/jtl_pkg.sv
// ----------------------------------------------------------------------------
// JSON token lexer package
// Shared token codes, character constants and the result and queue entry
// types used between the classifier, the queue and the output stage.
// ----------------------------------------------------------------------------
package jtl_pkg;

   // Default depth of the queue between classifier and output stage
   localparam int QUEUE_DEPTH_DEF = 4;

   // Token kinds carried on the result channel
   localparam logic [3:0] KIND_UNKNOWN  = 4'd0;
   localparam logic [3:0] KIND_STRING   = 4'd1;
   localparam logic [3:0] KIND_NUMBER   = 4'd2;
   localparam logic [3:0] KIND_BOOL     = 4'd3;
   localparam logic [3:0] KIND_NULL     = 4'd4;
   localparam logic [3:0] KIND_OPEN_SQ  = 4'd5;
   localparam logic [3:0] KIND_CLOSE_SQ = 4'd6;
   localparam logic [3:0] KIND_OPEN_CU  = 4'd7;
   localparam logic [3:0] KIND_CLOSE_CU = 4'd8;
   localparam logic [3:0] KIND_COMMA    = 4'd9;
   localparam logic [3:0] KIND_COLON    = 4'd10;
   localparam logic [3:0] KIND_END      = 4'd11;
   localparam logic [3:0] KIND_ERROR    = 4'd12;

   // Characters the lexer reacts to
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_PLUS      = 8'h2B;
   localparam logic [7:0] CH_DOT       = 8'h2E;
   localparam logic [7:0] CH_UPPER_E   = 8'h45;
   localparam logic [7:0] CH_LOWER_E   = 8'h65;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_RBRACKET  = 8'h5D;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;

   // Lexer scan mode
   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_STRING  = 2'd1,
      MODE_NUMBER  = 2'd2,
      MODE_LITERAL = 2'd3
   } scan_mode_type;

   // One token event
   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] vbyte;
      logic       valid;
      logic       done;
   } result_type;

   // Everything one text byte produces: one or two events
   typedef struct packed {
      logic       pair;
      result_type r0;
      result_type r1;
   } entry_type;

endpackage

// File: sv/jtl_front.sv
// ----------------------------------------------------------------------------
// JSON token lexer classifier
// Accepts text bytes, tracks the scan mode and writes the events of each
// byte as one entry into the queue.
// ----------------------------------------------------------------------------
module jtl_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               req_tlast,
   input  logic               q_full,
   output logic               q_push,
   output jtl_pkg::entry_type q_entry
);
   import jtl_pkg::*;

   typedef struct packed {
      logic          emit;
      result_type    res;
      scan_mode_type mode;
      logic          set_lit;
      logic [2:0]    left;
      logic          is_bool;
      logic          set_prev;
   } idle_lex_type;

   scan_mode_type mode_ff, mode_in;
   logic [7:0]    prev_ff, prev_in;
   logic [2:0]    left_ff, left_in;
   logic          bool_ff, bool_in;
   logic          accept;
   logic          emit;
   entry_type     ent;
   idle_lex_type  lex;

   function automatic logic is_num_byte(input logic [7:0] c);
      return (c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
             c == CH_DOT || c == CH_UPPER_E || c == CH_LOWER_E;
   endfunction

   function automatic result_type mk(input logic [3:0] kind, input logic [7:0] b,
                                     input logic valid, input logic done);
      result_type r;
      r.kind  = kind;
      r.vbyte = valid ? b : 8'd0;
      r.valid = valid;
      r.done  = done;
      return r;
   endfunction

   // Classify a byte seen between tokens
   function automatic idle_lex_type lex_idle(input logic [7:0] c);
      idle_lex_type l;
      l = '0;
      l.mode = MODE_IDLE;
      l.emit = 1'b1;
      l.res  = mk(KIND_UNKNOWN, 8'd0, 1'b0, 1'b1);
      case (c)
         CH_SPACE, CH_NEWLINE, CH_TAB: begin
            l.emit = 1'b0;
         end
         CH_QUOTE: begin
            l.emit     = 1'b0;
            l.mode     = MODE_STRING;
            l.set_prev = 1'b1;
         end
         CH_LBRACKET: l.res = mk(KIND_OPEN_SQ, 8'd0, 1'b0, 1'b1);
         CH_RBRACKET: l.res = mk(KIND_CLOSE_SQ, 8'd0, 1'b0, 1'b1);
         CH_LBRACE:   l.res = mk(KIND_OPEN_CU, 8'd0, 1'b0, 1'b1);
         CH_RBRACE:   l.res = mk(KIND_CLOSE_CU, 8'd0, 1'b0, 1'b1);
         CH_COMMA:    l.res = mk(KIND_COMMA, 8'd0, 1'b0, 1'b1);
         CH_COLON:    l.res = mk(KIND_COLON, 8'd0, 1'b0, 1'b1);
         CH_T, CH_F: begin
            l.mode    = MODE_LITERAL;
            l.set_lit = 1'b1;
            l.is_bool = 1'b1;
            l.left    = (c == CH_T) ? 3'd3 : 3'd4;
            l.res     = mk(KIND_BOOL, c, 1'b1, 1'b0);
         end
         CH_N: begin
            l.mode    = MODE_LITERAL;
            l.set_lit = 1'b1;
            l.is_bool = 1'b0;
            l.left    = 3'd3;
            l.res     = mk(KIND_NULL, 8'd0, 1'b0, 1'b1);
         end
         default: begin
            if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_MINUS) begin
               l.mode = MODE_NUMBER;
               l.res  = mk(KIND_NUMBER, c, 1'b1, 1'b0);
            end
         end
      endcase
      return l;
   endfunction

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign lex        = lex_idle(req_tdata);
   assign q_push     = accept && emit;
   assign q_entry    = ent;

   // Next mode and events of the current byte
   always_comb begin
      mode_in = mode_ff;
      prev_in = prev_ff;
      left_in = left_ff;
      bool_in = bool_ff;
      ent     = '0;
      emit    = 1'b0;
      if (req_tlast) begin
         emit    = 1'b1;
         mode_in = MODE_IDLE;
         prev_in = 8'd0;
         left_in = 3'd0;
         bool_in = 1'b0;
         if (mode_ff == MODE_STRING) begin
            ent.r0 = mk(KIND_ERROR, 8'd0, 1'b0, 1'b1);
         end else if (mode_ff == MODE_NUMBER) begin
            ent.pair = 1'b1;
            ent.r0   = mk(KIND_NUMBER, 8'd0, 1'b0, 1'b1);
            ent.r1   = mk(KIND_END, 8'd0, 1'b0, 1'b1);
         end else if (mode_ff == MODE_LITERAL && bool_ff) begin
            ent.pair = 1'b1;
            ent.r0   = mk(KIND_BOOL, 8'd0, 1'b0, 1'b1);
            ent.r1   = mk(KIND_END, 8'd0, 1'b0, 1'b1);
         end else begin
            ent.r0 = mk(KIND_END, 8'd0, 1'b0, 1'b1);
         end
      end else begin
         case (mode_ff)
            MODE_STRING: begin
               emit = 1'b1;
               if (req_tdata == CH_QUOTE && prev_ff != CH_BACKSLASH) begin
                  ent.r0  = mk(KIND_STRING, 8'd0, 1'b0, 1'b1);
                  mode_in = MODE_IDLE;
                  prev_in = 8'd0;
               end else begin
                  ent.r0  = mk(KIND_STRING, req_tdata, 1'b1, 1'b0);
                  prev_in = req_tdata;
               end
            end
            MODE_NUMBER: begin
               emit = 1'b1;
               if (is_num_byte(req_tdata)) begin
                  ent.r0 = mk(KIND_NUMBER, req_tdata, 1'b1, 1'b0);
               end else begin
                  // close the number, then lex the byte afresh
                  ent.r0   = mk(KIND_NUMBER, 8'd0, 1'b0, 1'b1);
                  ent.pair = lex.emit;
                  ent.r1   = lex.res;
                  mode_in  = lex.mode;
                  if (lex.set_lit) begin
                     left_in = lex.left;
                     bool_in = lex.is_bool;
                  end
                  if (lex.set_prev) begin
                     prev_in = req_tdata;
                  end
               end
            end
            MODE_LITERAL: begin
               left_in = left_ff - 3'd1;
               emit    = bool_ff;
               ent.r0  = mk(KIND_BOOL, req_tdata, 1'b1, left_in == 3'd0);
               if (left_in == 3'd0) begin
                  mode_in = MODE_IDLE;
                  bool_in = 1'b0;
               end
            end
            default: begin
               emit    = lex.emit;
               ent.r0  = lex.res;
               mode_in = lex.mode;
               if (lex.set_lit) begin
                  left_in = lex.left;
                  bool_in = lex.is_bool;
               end
               if (lex.set_prev) begin
                  prev_in = req_tdata;
               end
            end
         endcase
      end
   end

   // Advance scan state on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         prev_ff <= 8'd0;
         left_ff <= 3'd0;
         bool_ff <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         prev_ff <= prev_in;
         left_ff <= left_in;
         bool_ff <= bool_in;
      end
   end

   // A literal being counted down always has bytes left
   assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_LITERAL |-> left_ff != 3'd0)
      else $error("literal mode with no bytes left");

   // Only a quote opens a string from idle
   assert property (@(posedge clock) disable iff (reset)
      $past(accept) && $past(mode_ff) == MODE_IDLE && mode_ff == MODE_STRING
      |-> prev_ff == CH_QUOTE)
      else $error("string opened without a quote");

   // End of text always leaves the lexer idle
   assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> mode_ff == MODE_IDLE && bool_ff == 1'b0)
      else $error("state not cleared after end of text");

endmodule

// File: sv/jtl_queue.sv
// ----------------------------------------------------------------------------
// JSON token lexer entry queue
// Small FIFO of event entries between the classifier and the output stage.
// ----------------------------------------------------------------------------
module jtl_queue #(
   parameter int DEPTH = jtl_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  jtl_pkg::entry_type push_entry,
   input  logic               pop,
   output jtl_pkg::entry_type head_entry,
   output logic               full,
   output logic               empty
);
   import jtl_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type         mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   assign full       = (count_ff == CW'(DEPTH));
   assign empty      = (count_ff == '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   // Pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full || pop)
      else $error("push into full queue");

   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("pop from empty queue");

   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(DEPTH))
      else $error("queue fill level out of range");

endmodule

// File: sv/jtl_back.sv
// ----------------------------------------------------------------------------
// JSON token lexer output stage
// Unpacks queue entries into single events and drives the registered
// result channel.
// ----------------------------------------------------------------------------
module jtl_back (
   input  logic               clock,
   input  logic               reset,
   input  jtl_pkg::entry_type head_entry,
   input  logic               q_empty,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic [5:0]         rsp_tuser,
   output logic               rsp_tlast
);
   import jtl_pkg::*;

   result_type out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   logic       out_last_ff, out_last_in;
   logic       phase_ff, phase_in;
   logic       load;

   // Output register is free when empty or being taken
   assign load  = !out_valid_ff || rsp_tready;
   assign q_pop = load && !q_empty && (phase_ff || !head_entry.pair);

   // Select the event to present next
   always_comb begin
      out_in       = out_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff;
      phase_in     = phase_ff;
      if (load) begin
         out_valid_in = !q_empty;
         if (!q_empty) begin
            if (phase_ff) begin
               out_in      = head_entry.r1;
               out_last_in = 1'b1;
               phase_in    = 1'b0;
            end else begin
               out_in      = head_entry.r0;
               out_last_in = !head_entry.pair;
               phase_in    = head_entry.pair;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
   end

   // Hold payload until the transfer completes
   always_ff @(posedge clock) begin
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.vbyte;
   assign rsp_tuser  = {out_ff.done, out_ff.valid, out_ff.kind};
   assign rsp_tlast  = out_last_ff;

   // Second half of a pair keeps its entry at the head
   assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> !q_empty && head_entry.pair)
      else $error("second event pending without a paired entry");

   // Entering the second half means the first half was just loaded
   assert property (@(posedge clock) disable iff (reset)
      $rose(phase_ff) |-> out_valid_ff && !out_last_ff)
      else $error("pair split without first event presented");

   // An event without a value byte carries a zero byte
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.valid == 1'b0 |-> out_ff.vbyte == 8'd0)
      else $error("value byte set without value flag");

endmodule

// File: sv/json_token_lexer_unit.sv
// ----------------------------------------------------------------------------
// JSON token lexer
// Streaming lexer turning JSON text bytes into token events.
// ----------------------------------------------------------------------------
// Input channel req_*: one text byte per transfer in req_tdata; req_tlast set
// marks end of text (byte ignored) and yields End, or Error inside a string.
// Result channel rsp_*: one token event per transfer. rsp_tdata carries the
// value byte, rsp_tuser the token kind and flags, rsp_tlast the final event
// caused by one input byte.
// A byte yields zero, one or two events. The classifier takes one byte per
// cycle while the entry queue has room; the output stage sends one event per
// cycle while the receiver takes them, and the two events of one byte go
// out in turn. Events pass through the entry queue, then the output register.
// The output register and the entry queue let bytes keep flowing while a
// finished event waits; when the receiver stalls, the queue fills and
// req_tready drops, holding the event on rsp_* stable until taken.
// Reset returns the lexer to idle between tokens and empties the queue.
// ----------------------------------------------------------------------------
module json_token_lexer_unit #(
   parameter int QUEUE_DEPTH = jtl_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   input  logic       req_tlast,   // end_of_text
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] value_byte
   output logic [5:0] rsp_tuser,   // [3:0] token_kind, [4] value_valid, [5] token_done
   output logic       rsp_tlast    // last_of_run
);
   import jtl_pkg::*;

   entry_type push_entry;
   entry_type head_entry;
   logic      q_push;
   logic      q_pop;
   logic      q_full;
   logic      q_empty;

   jtl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   jtl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   jtl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON token lexer testbench
// Streams directed and random JSON-like text into the lexer. Both channels
// stall at random. Every token event is checked field by field against
// events predicted from each accepted input byte.
// ----------------------------------------------------------------------------
module tb;
   import jtl_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int TOKEN_TARGET = 1050;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [5:0] rsp_tuser;
   logic       rsp_tlast;

   logic       quiet_phase = 1'b0;
   int         cycles = 0;
   int         token_items = 0;

   // One predicted token event, packed for a single compare
   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] vbyte;
      logic       valid;
      logic       done;
      logic       last;
   } token_event_type;

   class token_scoreboard;
      scan_mode_type   mode;
      logic [7:0]      prev_byte;
      logic [2:0]      lit_left;
      logic            lit_bool;
      token_event_type pending[$];
      int              errors;

      function new();
         clear_state();
         errors = 0;
      endfunction

      function void clear_state();
         mode = MODE_IDLE;
         prev_byte = 8'h00;
         lit_left = 3'd0;
         lit_bool = 1'b0;
      endfunction

      function void add_event(logic [3:0] kind, logic [7:0] vbyte, logic valid, logic done);
         token_event_type ev;
         ev.kind = kind;
         ev.vbyte = valid ? vbyte : 8'h00;
         ev.valid = valid;
         ev.done = done;
         ev.last = 1'b0;
         pending.push_back(ev);
      endfunction

      function bit is_number_byte(logic [7:0] c);
         return (c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
                c == CH_DOT || c == CH_UPPER_E || c == CH_LOWER_E;
      endfunction

      // Lex a byte that arrives between tokens
      function void lex_fresh(logic [7:0] c);
         case (c)
            CH_SPACE, CH_NEWLINE, CH_TAB: ;
            CH_QUOTE: begin
               mode = MODE_STRING;
               prev_byte = c;
            end
            CH_LBRACKET: add_event(KIND_OPEN_SQ, 8'h00, 1'b0, 1'b1);
            CH_RBRACKET: add_event(KIND_CLOSE_SQ, 8'h00, 1'b0, 1'b1);
            CH_LBRACE:   add_event(KIND_OPEN_CU, 8'h00, 1'b0, 1'b1);
            CH_RBRACE:   add_event(KIND_CLOSE_CU, 8'h00, 1'b0, 1'b1);
            CH_COMMA:    add_event(KIND_COMMA, 8'h00, 1'b0, 1'b1);
            CH_COLON:    add_event(KIND_COLON, 8'h00, 1'b0, 1'b1);
            CH_T, CH_F: begin
               mode = MODE_LITERAL;
               lit_bool = 1'b1;
               lit_left = (c == CH_T) ? 3'd3 : 3'd4;
               add_event(KIND_BOOL, c, 1'b1, 1'b0);
            end
            CH_N: begin
               mode = MODE_LITERAL;
               lit_bool = 1'b0;
               lit_left = 3'd3;
               add_event(KIND_NULL, 8'h00, 1'b0, 1'b1);
            end
            default: begin
               if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_MINUS) begin
                  mode = MODE_NUMBER;
                  add_event(KIND_NUMBER, c, 1'b1, 1'b0);
               end else begin
                  add_event(KIND_UNKNOWN, 8'h00, 1'b0, 1'b1);
               end
            end
         endcase
      endfunction

      // Predict the events of one accepted input; return how many
      function int note_input(logic [7:0] c, logic end_flag);
         int start_count;
         start_count = pending.size();
         if (end_flag) begin
            if (mode == MODE_STRING) begin
               add_event(KIND_ERROR, 8'h00, 1'b0, 1'b1);
            end else begin
               if (mode == MODE_NUMBER)
                  add_event(KIND_NUMBER, 8'h00, 1'b0, 1'b1);
               else if (mode == MODE_LITERAL && lit_bool)
                  add_event(KIND_BOOL, 8'h00, 1'b0, 1'b1);
               add_event(KIND_END, 8'h00, 1'b0, 1'b1);
            end
            clear_state();
         end else begin
            case (mode)
               MODE_STRING: begin
                  if (c == CH_QUOTE && prev_byte != CH_BACKSLASH) begin
                     add_event(KIND_STRING, 8'h00, 1'b0, 1'b1);
                     mode = MODE_IDLE;
                     prev_byte = 8'h00;
                  end else begin
                     add_event(KIND_STRING, c, 1'b1, 1'b0);
                     prev_byte = c;
                  end
               end
               MODE_NUMBER: begin
                  if (is_number_byte(c)) begin
                     add_event(KIND_NUMBER, c, 1'b1, 1'b0);
                  end else begin
                     // close the number, then lex the closing byte itself
                     add_event(KIND_NUMBER, 8'h00, 1'b0, 1'b1);
                     mode = MODE_IDLE;
                     lex_fresh(c);
                  end
               end
               MODE_LITERAL: begin
                  lit_left = lit_left - 3'd1;
                  if (lit_bool)
                     add_event(KIND_BOOL, c, 1'b1, lit_left == 3'd0);
                  if (lit_left == 3'd0) begin
                     mode = MODE_IDLE;
                     lit_bool = 1'b0;
                  end
               end
               default: lex_fresh(c);
            endcase
         end
         if (pending.size() > start_count)
            pending[pending.size() - 1].last = 1'b1;
         return pending.size() - start_count;
      endfunction

      // Compare one result transfer with the oldest predicted event
      function void check_result(logic [7:0] data, logic [5:0] user, logic last);
         token_event_type got;
         token_event_type want;
         got.kind = user[3:0];
         got.vbyte = data;
         got.valid = user[4];
         got.done = user[5];
         got.last = last;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected event: kind %0d byte %02h valid %b done %b last %b",
                        got.kind, got.vbyte, got.valid, got.done, got.last);
            return;
         end
         want = pending.pop_front();
         if (got != want) begin
            errors++;
            if (errors <= 10) begin
               $display("event mismatch: expected kind %0d byte %02h valid %b done %b last %b",
                        want.kind, want.vbyte, want.valid, want.done, want.last);
               $display("                got      kind %0d byte %02h valid %b done %b last %b",
                        got.kind, got.vbyte, got.valid, got.done, got.last);
            end
         end
      endfunction
   endclass

   token_scoreboard sb;

   json_token_lexer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the receiver at random, except in the quiet phase
   always @(posedge clock) begin
      rsp_tready <= quiet_phase || ($urandom_range(99) >= 24);
   end

   // Check results mid-cycle, where every signal is settled
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // Abort a run that hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Offer one input item and hold it until the transfer
   task automatic send_item(input logic [7:0] c, input logic end_flag);
      while (!quiet_phase && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tlast <= end_flag;
      @(negedge clock);
      while (!req_tready)
         @(negedge clock);
      void'(sb.note_input(c, end_flag));
      // count every input transfer
      token_items++;
      @(posedge clock);
   endtask

   task automatic send_byte(input logic [7:0] c);
      send_item(c, 1'b0);
   endtask

   task automatic send_end();
      send_item(8'($urandom_range(255)), 1'b1);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i]);
   endtask

   initial begin
      int         pick;
      int         len;
      int         cut;
      logic [7:0] c;
      string      word;

      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty string, number closed by a comma, true, brackets
      send_text("[{\"\":-1e+5,true}]");
      // null skips its next three bytes, whatever they are
      send_byte(CH_N);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(CH_TAB);
      send_byte(8'h80);
      // escaped quote, then end of text inside the string
      send_text("\"\\\"");
      send_end();
      // end of text closes a number; a second end in idle
      send_byte(CH_NINE);
      send_end();
      send_end();

      // Random: mostly well-formed tokens, some noise and cut tokens
      while (token_items < TOKEN_TARGET) begin
         quiet_phase <= (token_items >= 400 && token_items < 650);
         pick = $urandom_range(99);
         if (pick < 15) begin
            case ($urandom_range(5))
               0: send_byte(CH_LBRACKET);
               1: send_byte(CH_RBRACKET);
               2: send_byte(CH_LBRACE);
               3: send_byte(CH_RBRACE);
               4: send_byte(CH_COMMA);
               default: send_byte(CH_COLON);
            endcase
         end else if (pick < 23) begin
            case ($urandom_range(2))
               0: send_byte(CH_SPACE);
               1: send_byte(CH_NEWLINE);
               default: send_byte(CH_TAB);
            endcase
         end else if (pick < 43) begin
            // string with random content and escaped quotes
            send_byte(CH_QUOTE);
            len = $urandom_range(6);
            for (int i = 0; i < len; i++) begin
               cut = $urandom_range(99);
               if (cut < 12) begin
                  send_byte(CH_BACKSLASH);
                  send_byte(CH_QUOTE);
               end else if (cut < 30) begin
                  send_byte(8'($urandom_range(8'h7A, 8'h61)));
               end else begin
                  send_byte(8'($urandom_range(255)));
               end
            end
            if ($urandom_range(9) == 0)
               send_end();
            else
               send_byte(CH_QUOTE);
         end else if (pick < 60) begin
            // number: sign or digit, then digits, signs, dots and exponents
            if ($urandom_range(4) == 0)
               send_byte(CH_MINUS);
            else
               send_byte(8'(CH_ZERO + $urandom_range(9)));
            len = $urandom_range(5);
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(9))
                  0: c = CH_PLUS;
                  1: c = CH_MINUS;
                  2: c = CH_DOT;
                  3: c = CH_UPPER_E;
                  4: c = CH_LOWER_E;
                  default: c = 8'(CH_ZERO + $urandom_range(9));
               endcase
               send_byte(c);
            end
         end else if (pick < 70) begin
            // boolean, sometimes with garbled bytes or cut by end of text
            word = ($urandom_range(1) == 0) ? "true" : "false";
            cut = ($urandom_range(7) == 0) ? $urandom_range(word.len() - 1, 1) : word.len();
            for (int i = 0; i < cut; i++) begin
               if (i > 0 && $urandom_range(99) < 15)
                  send_byte(8'($urandom_range(255)));
               else
                  send_byte(word[i]);
            end
            if (cut < word.len())
               send_end();
         end else if (pick < 77) begin
            // null: the three bytes after n are skipped unseen
            send_byte(CH_N);
            if ($urandom_range(9) == 0) begin
               send_end();
            end else begin
               for (int i = 0; i < 3; i++)
                  send_byte(8'($urandom_range(255)));
            end
         end else if (pick < 95) begin
            send_byte(8'($urandom_range(255)));
         end else begin
            send_end();
         end
      end
      req_tvalid <= 1'b0;
      quiet_phase <= 1'b0;

      // Drain, then let any stray event show up
      while (sb.pending.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
